/* rtl/field_sample_decode_scale_macros.svh */
// Assertion macros for the field sample decode and scale block.
`ifndef FIELD_SAMPLE_DECODE_SCALE_MACROS_SVH
`define FIELD_SAMPLE_DECODE_SCALE_MACROS_SVH
`ifndef SYNTHESIS
// Check a property while out of reset
`define FSDS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Check a property on every edge, reset included
`define FSDS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define FSDS_ASSERT(lbl, prop, msg)
`define FSDS_ASSERT_RST(lbl, prop, msg)
`endif
`endif

/* rtl/fsds_pkg.sv */
// Shared types, constants and helper functions of the decode and scale block.
`default_nettype none
package fsds_pkg;

  localparam int unsigned SizeClass8  = 8;
  localparam int unsigned SizeClass16 = 16;
  localparam logic [31:0] DefaultNan  = 32'hFFC0_0000;
  localparam logic [31:0] QuietMask   = 32'h0040_0000;

  typedef enum logic [2:0] {
    REG_FIELD_MASK = 3'd0,
    REG_FIELD_SHIFT = 3'd1,
    REG_FIELD_SIZE = 3'd2,
    REG_VALUE_KIND = 3'd3,
    REG_BYPASS = 3'd4,
    REG_OFFSET = 3'd5,
    REG_GAIN = 3'd6
  } fsds_reg_e;

  typedef enum logic [1:0] {
    KIND_UNSIGNED = 2'd0,
    KIND_SIGNED = 2'd1,
    KIND_FLOAT = 2'd2
  } fsds_kind_e;

  typedef struct packed {
    logic [63:0] field_mask;
    logic [5:0]  field_shift;
    logic [5:0]  field_size_bits;
    logic [1:0]  value_kind;
  } fsds_dec_cfg_t;

  typedef struct packed {
    logic dec1;
    logic dec2;
    logic add1;
    logic add2;
    logic mul1;
    logic mul2;
    logic mul3;
  } fsds_stage_en_t;

  // Leading zero count, 48 when all bits are clear
  function automatic logic [5:0] lzc48(input logic [47:0] v);
    logic [5:0] n;
    n = 6'd48;
    for (int i = 0; i < 48; i++) begin
      if (v[i]) n = 6'(47 - i);
    end
    return n;
  endfunction

  function automatic logic is_nan(input logic [31:0] f);
    return (&f[30:23]) && (|f[22:0]);
  endfunction

  function automatic logic is_inf(input logic [31:0] f);
    return (&f[30:23]) && !(|f[22:0]);
  endfunction

endpackage
`default_nettype wire

/* rtl/fsds_in_if.sv */
// Input channel: one raw memory word per item.
`default_nettype none
interface fsds_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] raw_word;
  modport source (output valid, output raw_word, input ready);
  modport sink (input valid, input raw_word, output ready);
endinterface
`default_nettype wire

/* rtl/fsds_out_if.sv */
// Output channel: decoded and scaled float patterns per item.
`default_nettype none
interface fsds_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] raw_float;
  logic [31:0] scaled_float;
  modport source (output valid, output raw_float, output scaled_float, input ready);
  modport sink (input valid, input raw_float, input scaled_float, output ready);
endinterface
`default_nettype wire

/* rtl/field_sample_decode_scale.sv */
// Top level: decodes a field of a raw word to binary32 and scales it.
//
// Input channel samp_i carries one 64-bit raw word per item; output channel
// res_o returns the decoded value (raw_float) and (raw + offset) * gain
// (scaled_float), or the decoded value again when bypass is set. Both use a
// valid/ready handshake; an item moves when valid and ready are high at a
// clock edge.
// The datapath is seven register stages: field extract, int to float,
// adder align, adder normalize/round, multiply, product normalize, product
// round. One item is taken every cycle when the receiver keeps ready high.
// Each stage holds its own valid bit. When the receiver stalls, the last
// stage holds and earlier stages keep filling any empty slots, so ready
// drops only once all seven stages hold items.
// Configuration must be written through cfg_we_i/cfg_idx_i/cfg_wdata_i only
// while no items are in flight; the block does not enforce this. Reset
// empties the pipeline and loads the default registers: 32-bit float field
// at bit zero, offset 0.0, gain 1.0.
`default_nettype none
`include "field_sample_decode_scale_macros.svh"
module field_sample_decode_scale import fsds_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [63:0] cfg_wdata_i,
  fsds_in_if.sink          samp_i,
  fsds_out_if.source       res_o
);

  localparam int unsigned NumStages = 7;
  localparam int unsigned RawTaps   = 5;

  logic [63:0] field_mask_q;
  logic [5:0]  field_shift_q;
  logic [5:0]  field_size_q;
  logic [1:0]  value_kind_q;
  logic        bypass_q;
  logic [31:0] offset_q;
  logic [31:0] gain_q;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_mask_q <= 64'h0000_0000_FFFF_FFFF;
      field_shift_q <= 6'd0;
      field_size_q <= 6'd32;
      value_kind_q <= KIND_FLOAT;
      bypass_q <= 1'b0;
      offset_q <= 32'h0000_0000;
      gain_q <= 32'h3F80_0000;
    end else if (cfg_we_i) begin
      unique case (fsds_reg_e'(cfg_idx_i))
        REG_FIELD_MASK: field_mask_q <= cfg_wdata_i;
        REG_FIELD_SHIFT: field_shift_q <= cfg_wdata_i[5:0];
        REG_FIELD_SIZE: field_size_q <= cfg_wdata_i[5:0];
        REG_VALUE_KIND: value_kind_q <= cfg_wdata_i[1:0];
        REG_BYPASS: bypass_q <= cfg_wdata_i[0];
        REG_OFFSET: offset_q <= cfg_wdata_i[31:0];
        REG_GAIN: gain_q <= cfg_wdata_i[31:0];
        default: ;
      endcase
    end
  end

  // Stage enables: a stage advances when empty or when the next one advances
  logic [NumStages-1:0] v_q;
  logic [NumStages-1:0] en;
  fsds_stage_en_t       stage_en;

  always_comb begin
    en[NumStages-1] = !v_q[NumStages-1] || res_o.ready;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign stage_en = '{dec1: en[0], dec2: en[1], add1: en[2], add2: en[3],
                      mul1: en[4], mul2: en[5], mul3: en[6]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= samp_i.valid;
      for (int k = 1; k < NumStages; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  assign samp_i.ready = en[0];

  fsds_dec_cfg_t dec_cfg;
  assign dec_cfg = '{field_mask: field_mask_q, field_shift: field_shift_q,
                     field_size_bits: field_size_q, value_kind: value_kind_q};

  logic [31:0] raw_float;
  logic [31:0] sum_float;
  logic [31:0] prod_float;

  fsds_decode u_decode (
    .clk_i       (clk_i),
    .en_i        (stage_en),
    .cfg_i       (dec_cfg),
    .raw_word_i  (samp_i.raw_word),
    .raw_float_o (raw_float)
  );

  fsds_fadd u_fadd (
    .clk_i (clk_i),
    .en_i  (stage_en),
    .a_i   (raw_float),
    .b_i   (offset_q),
    .sum_o (sum_float)
  );

  fsds_fmul u_fmul (
    .clk_i  (clk_i),
    .en_i   (stage_en),
    .a_i    (sum_float),
    .b_i    (gain_q),
    .prod_o (prod_float)
  );

  // Carry the decoded value alongside the scaling stages
  logic [RawTaps-1:0][31:0] raw_tap_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) raw_tap_q[0] <= raw_float;
    for (int k = 1; k < RawTaps; k++) begin
      if (en[k+2]) raw_tap_q[k] <= raw_tap_q[k-1];
    end
  end

  assign res_o.valid = v_q[NumStages-1];
  assign res_o.raw_float = raw_tap_q[RawTaps-1];
  assign res_o.scaled_float = bypass_q ? raw_tap_q[RawTaps-1] : prod_float;

  `FSDS_ASSERT_RST(a_rst_no_out, !rst_ni |=> !res_o.valid, "result valid during reset")
  `FSDS_ASSERT(a_bubble_ready, ($countones(v_q) != NumStages) |-> samp_i.ready,
               "input stalled with an empty stage")
  `FSDS_ASSERT(a_accept_fill, (samp_i.valid && samp_i.ready) |=> v_q[0],
               "accepted item missing from first stage")

endmodule
`default_nettype wire

/* rtl/fsds_decode.sv */
// Field extraction and integer to binary32 conversion, two stages.
`default_nettype none
module fsds_decode import fsds_pkg::*; (
  input  wire logic           clk_i,
  input  wire fsds_stage_en_t en_i,
  input  wire fsds_dec_cfg_t  cfg_i,
  input  wire logic [63:0]    raw_word_i,
  output logic [31:0]         raw_float_o
);

  logic [63:0] fld;
  logic        cls8, cls16, is_signed, is_flt;
  logic [31:0] ext, mag;
  logic        neg;
  logic        flt_q, neg_q;
  logic [31:0] bits_q;

  // Mask, shift and sign-extend the field per size class
  always_comb begin
    fld = (raw_word_i & cfg_i.field_mask) >> cfg_i.field_shift;
    cls8 = cfg_i.field_size_bits <= 6'(SizeClass8);
    cls16 = cfg_i.field_size_bits <= 6'(SizeClass16);
    is_signed = cfg_i.value_kind == KIND_SIGNED;
    is_flt = 1'b0;
    if (cls8) begin
      ext = {{24{is_signed & fld[7]}}, fld[7:0]};
    end else if (cls16) begin
      ext = {{16{is_signed & fld[15]}}, fld[15:0]};
    end else begin
      ext = fld[31:0];
      is_flt = cfg_i.value_kind == KIND_FLOAT;
    end
    neg = is_signed & ext[31];
    mag = neg ? (~ext + 32'd1) : ext;
  end

  always_ff @(posedge clk_i) begin
    if (en_i.dec1) begin
      flt_q <= is_flt;
      neg_q <= is_signed & ext[31] & !is_flt;
      bits_q <= is_flt ? ext : mag;
    end
  end

  logic [5:0]  lz;
  logic [31:0] norm;
  logic [7:0]  expo;
  logic        inc;
  logic [30:0] mag31;
  logic [31:0] res;

  // Normalize the magnitude and round to nearest even
  always_comb begin
    lz = lzc48({bits_q, 16'hFFFF});
    norm = bits_q << lz[4:0];
    expo = 8'(9'd158 - 9'(lz));
    inc = norm[7] & (norm[8] | (|norm[6:0]));
    mag31 = {expo, norm[30:8]} + 31'(inc);
    if (flt_q) begin
      res = bits_q;
    end else if (bits_q == 32'd0) begin
      res = '0;
    end else begin
      res = {neg_q, mag31};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.dec2) raw_float_o <= res;
  end

endmodule
`default_nettype wire

/* rtl/fsds_fadd.sv */
// Binary32 adder, align and add stage followed by normalize and round stage.
`default_nettype none
module fsds_fadd import fsds_pkg::*; (
  input  wire logic           clk_i,
  input  wire fsds_stage_en_t en_i,
  input  wire logic [31:0]    a_i,
  input  wire logic [31:0]    b_i,
  output logic [31:0]         sum_o
);

  logic        swap, eff_sub;
  logic [31:0] x, y;
  logic [7:0]  ex, ey, d;
  logic [4:0]  dcap;
  logic [23:0] mx, my;
  logic [53:0] al;
  logic [26:0] xw, yal;
  logic [27:0] sum;
  logic        spec;
  logic [31:0] spec_val;

  // Order by magnitude, align the smaller operand, add or subtract
  always_comb begin
    swap = b_i[30:0] > a_i[30:0];
    x = swap ? b_i : a_i;
    y = swap ? a_i : b_i;
    ex = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
    ey = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
    mx = {|x[30:23], x[22:0]};
    my = {|y[30:23], y[22:0]};
    d = ex - ey;
    dcap = (d > 8'd27) ? 5'd27 : d[4:0];
    al = {my, 30'd0} >> dcap;
    yal = {al[53:28], al[27] | (|al[26:0])};
    xw = {mx, 3'b000};
    eff_sub = x[31] ^ y[31];
    sum = eff_sub ? ({1'b0, xw} - {1'b0, yal}) : ({1'b0, xw} + {1'b0, yal});
    spec = 1'b1;
    if (is_nan(a_i)) begin
      spec_val = a_i | QuietMask;
    end else if (is_nan(b_i)) begin
      spec_val = b_i | QuietMask;
    end else if (is_inf(a_i) && is_inf(b_i) && (a_i[31] != b_i[31])) begin
      spec_val = DefaultNan;
    end else if (is_inf(a_i)) begin
      spec_val = a_i;
    end else if (is_inf(b_i)) begin
      spec_val = b_i;
    end else begin
      spec = 1'b0;
      spec_val = '0;
    end
  end

  logic        spec_q, sign_q, sub_q;
  logic [31:0] spec_val_q;
  logic [7:0]  ex_q;
  logic [27:0] sum_q;

  always_ff @(posedge clk_i) begin
    if (en_i.add1) begin
      spec_q <= spec;
      spec_val_q <= spec_val;
      sign_q <= x[31];
      sub_q <= eff_sub;
      ex_q <= ex;
      sum_q <= sum;
    end
  end

  logic [5:0]  lz;
  logic [4:0]  sh;
  logic [26:0] n27;
  logic [8:0]  ef;
  logic        inc;
  logic [30:0] mag31;
  logic [31:0] res;

  // Normalize, stop at the subnormal boundary, round to nearest even
  always_comb begin
    lz = lzc48({sum_q[26:0], 21'h1F_FFFF});
    sh = '0;
    if (sum_q[27]) begin
      n27 = {sum_q[27:2], sum_q[1] | sum_q[0]};
      ef = {1'b0, ex_q} + 9'd1;
    end else begin
      if ({2'b00, lz} < ex_q) begin
        sh = lz[4:0];
      end else begin
        sh = 5'(ex_q - 8'd1);
      end
      n27 = sum_q[26:0] << sh;
      ef = n27[26] ? ({1'b0, ex_q} - 9'(sh)) : 9'd0;
    end
    inc = n27[2] & (n27[3] | (|n27[1:0]));
    mag31 = {ef[7:0], n27[25:3]} + 31'(inc);
    if (spec_q) begin
      res = spec_val_q;
    end else if (sum_q == 28'd0) begin
      res = {sign_q & !sub_q, 31'd0};
    end else if (ef >= 9'd255) begin
      res = {sign_q, 8'hFF, 23'd0};
    end else begin
      res = {sign_q, mag31};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.add2) sum_o <= res;
  end

endmodule
`default_nettype wire

/* rtl/fsds_fmul.sv */
// Binary32 multiplier: multiply, normalize, then denormalize and round.
`default_nettype none
module fsds_fmul import fsds_pkg::*; (
  input  wire logic           clk_i,
  input  wire fsds_stage_en_t en_i,
  input  wire logic [31:0]    a_i,
  input  wire logic [31:0]    b_i,
  output logic [31:0]         prod_o
);

  logic              a_zero, b_zero, sign, spec;
  logic [31:0]       spec_val;
  logic [7:0]        ea, eb;
  logic [23:0]       ma, mb;
  logic signed [10:0] e1;

  // Handle special operands and form the significand product
  always_comb begin
    a_zero = a_i[30:0] == 31'd0;
    b_zero = b_i[30:0] == 31'd0;
    sign = a_i[31] ^ b_i[31];
    ea = (a_i[30:23] == 8'd0) ? 8'd1 : a_i[30:23];
    eb = (b_i[30:23] == 8'd0) ? 8'd1 : b_i[30:23];
    ma = {|a_i[30:23], a_i[22:0]};
    mb = {|b_i[30:23], b_i[22:0]};
    e1 = $signed(11'(ea)) + $signed(11'(eb)) - 11'sd127;
    spec = 1'b1;
    if (is_nan(a_i)) begin
      spec_val = a_i | QuietMask;
    end else if (is_nan(b_i)) begin
      spec_val = b_i | QuietMask;
    end else if ((is_inf(a_i) && b_zero) || (is_inf(b_i) && a_zero)) begin
      spec_val = DefaultNan;
    end else if (is_inf(a_i) || is_inf(b_i)) begin
      spec_val = {sign, 8'hFF, 23'd0};
    end else if (a_zero || b_zero) begin
      spec_val = {sign, 31'd0};
    end else begin
      spec = 1'b0;
      spec_val = '0;
    end
  end

  logic              spec1_q, sign1_q;
  logic [31:0]       spec_val1_q;
  logic [47:0]       p_q;
  logic signed [10:0] e1_q;

  always_ff @(posedge clk_i) begin
    if (en_i.mul1) begin
      spec1_q <= spec;
      spec_val1_q <= spec_val;
      sign1_q <= sign;
      p_q <= ma * mb;
      e1_q <= e1;
    end
  end

  logic [5:0] lz;

  // Bring the leading one to the top of the product
  always_comb begin
    lz = lzc48(p_q);
  end

  logic              spec2_q, sign2_q;
  logic [31:0]       spec_val2_q;
  logic [47:0]       n2_q;
  logic signed [10:0] e2_q;

  always_ff @(posedge clk_i) begin
    if (en_i.mul2) begin
      spec2_q <= spec1_q;
      spec_val2_q <= spec_val1_q;
      sign2_q <= sign1_q;
      n2_q <= p_q << lz;
      e2_q <= e1_q + 11'sd1 - $signed({5'd0, lz});
    end
  end

  logic              tiny, stick, inc;
  logic signed [10:0] rs_full;
  logic [5:0]        rs;
  logic [95:0]       w;
  logic [47:0]       shd;
  logic [7:0]        ef;
  logic [30:0]       mag31;
  logic [31:0]       res;

  // Shift into the subnormal range when needed, round to nearest even
  always_comb begin
    tiny = e2_q < 11'sd1;
    rs_full = 11'sd1 - e2_q;
    rs = (tiny && (rs_full > 11'sd50)) ? 6'd50 : (tiny ? rs_full[5:0] : 6'd0);
    w = {n2_q, 48'd0} >> rs;
    shd = w[95:48];
    stick = |w[47:0];
    ef = tiny ? 8'd0 : e2_q[7:0];
    inc = shd[23] & (shd[24] | (|shd[22:0]) | stick);
    mag31 = {ef, shd[46:24]} + 31'(inc);
    if (spec2_q) begin
      res = spec_val2_q;
    end else if (e2_q >= 11'sd255) begin
      res = {sign2_q, 8'hFF, 23'd0};
    end else begin
      res = {sign2_q, mag31};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.mul3) prod_o <= res;
  end

endmodule
`default_nettype wire
